FILE: hw/rtl/sle_pkg.sv
// sle_pkg: shared types and constants for the sorted list engine
// no dependencies; imported by sle_cell, the core and the testbench
`timescale 1ns / 1ps

package sle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int KEY_IN_W = 16;
  localparam int HANDLE_W = 16;
  localparam int POS_IN_W = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // broadcast to every cell for the request being accepted
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/sle_cell.sv
// sle_cell: one list slot, holds a key and a handle and shifts with its neighbors
// depends on sle_pkg for the cell control struct and the handle width
`timescale 1ns / 1ps

module sle_cell #(
  parameter int INDEX = 0,
  parameter int KEY_W = 16,
  parameter int CNT_W = 5,
  parameter int POS_W = 5
) (
  input  logic                      clk_i,
  input  sle_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [POS_W-1:0]          pos_i,
  input  logic [KEY_W-1:0]          new_key_i,
  input  logic [sle_pkg::HANDLE_W-1:0] new_handle_i,
  input  logic                      left_lt_i,
  input  logic [KEY_W-1:0]          left_key_i,
  input  logic [sle_pkg::HANDLE_W-1:0] left_handle_i,
  input  logic [KEY_W-1:0]          right_key_i,
  input  logic [sle_pkg::HANDLE_W-1:0] right_handle_i,
  output logic                      lt_o,
  output logic [KEY_W-1:0]          key_o,
  output logic [sle_pkg::HANDLE_W-1:0] handle_o
);
  import sle_pkg::*;

  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                occupied;
  logic                at_or_after;

  assign occupied    = CNT_W'(INDEX) < count_i;
  assign at_or_after = POS_W'(INDEX) >= pos_i;
  // stored entries are sorted, so the less-than flags form a prefix
  assign lt_o        = occupied && (key_q < new_key_i);

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.ins && !lt_o) begin
      if (left_lt_i) begin
        key_d    = new_key_i;
        handle_d = new_handle_i;
      end else begin
        key_d    = left_key_i;
        handle_d = left_handle_i;
      end
    end else if (ctrl_i.rem && at_or_after) begin
      key_d    = right_key_i;
      handle_d = right_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

FILE: hw/rtl/sorted_list_engine_core.sv
// sorted_list_engine_core: top level, entry count, request decode, result register
// depends on sle_pkg and sle_cell
`timescale 1ns / 1ps

// Sorted list of up to CAPACITY entries (handle plus key) kept in ascending key
// order in a row of cells. An insert lands ahead of equal keys; a remove closes
// the gap; a read returns the entry at a position. Every request gives one result
// with the entry count after it. One request is taken per cycle: all cells compare
// their key against the new key and shift in the same cycle, and the result sits
// in an output register from the cycle after acceptance. A new request is taken while
// the result register is empty or its result is being taken in that cycle.
// Entry storage needs no initialization after reset.
module sorted_list_engine_core #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sle_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sle_pkg::ACTION_W-1:0]  action_i,
  input  logic [sle_pkg::KEY_IN_W-1:0]  sort_key_i,
  input  logic [sle_pkg::HANDLE_W-1:0]  entry_handle_i,
  input  logic [sle_pkg::POS_IN_W-1:0]  position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sle_pkg::HANDLE_W-1:0]  out_handle_o,
  output logic [sle_pkg::KEY_IN_W-1:0]  out_key_o,
  output logic [sle_pkg::COUNT_W-1:0]   entry_count_o,
  output logic [sle_pkg::STATUS_W-1:0]  status_o
);
  import sle_pkg::*;

  localparam int KW   = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = (CW > POS_IN_W) ? CW : POS_IN_W;
  localparam int RD_N = (CAPACITY < (1 << POS_IN_W)) ? CAPACITY : (1 << POS_IN_W);

  logic                in_acc;
  logic [CW-1:0]       count_q, count_d;
  logic [PW-1:0]       pos_ext, cnt_ext;
  logic [KW-1:0]       new_key;
  cell_ctrl_t          ctrl;

  logic                lt_w     [CAPACITY];
  logic [KW-1:0]       key_w    [CAPACITY];
  logic [HANDLE_W-1:0] handle_w [CAPACITY];

  logic [KW-1:0]       rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  logic                out_valid_q;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [KEY_IN_W-1:0] out_key_q, out_key_d;
  logic [COUNT_W-1:0]  out_count_q;
  status_e             status_q, status_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pos_ext    = PW'(position_i);
  assign cnt_ext    = PW'(count_q);
  assign new_key    = sort_key_i[KW-1:0];

  // read mux, only the first positions are addressable
  always_comb begin
    rd_key    = '0;
    rd_handle = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (PW'(i) == pos_ext) begin
        rd_key    = key_w[i];
        rd_handle = handle_w[i];
      end
    end
  end

  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    status_d     = ST_DONE;
    out_handle_d = '0;
    out_key_d    = '0;
    unique case (action_i)
      ACT_INSERT: begin
        if (count_q == CW'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = in_acc;
          count_d  = count_q + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.rem = in_acc;
          count_d  = count_q - 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          out_handle_d = rd_handle;
          out_key_d    = KEY_IN_W'(rd_key);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                left_lt;
    logic [KW-1:0]       left_key, right_key;
    logic [HANDLE_W-1:0] left_handle, right_handle;

    if (g == 0) begin : g_first
      assign left_lt     = 1'b1;
      assign left_key    = '0;
      assign left_handle = '0;
    end else begin : g_mid
      assign left_lt     = lt_w[g-1];
      assign left_key    = key_w[g-1];
      assign left_handle = handle_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_key    = key_w[g];
      assign right_handle = handle_w[g];
    end else begin : g_inner
      assign right_key    = key_w[g+1];
      assign right_handle = handle_w[g+1];
    end

    sle_cell #(
      .INDEX (g),
      .KEY_W (KW),
      .CNT_W (CW),
      .POS_W (PW)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .count_i        (count_q),
      .pos_i          (pos_ext),
      .new_key_i      (new_key),
      .new_handle_i   (entry_handle_i),
      .left_lt_i      (left_lt),
      .left_key_i     (left_key),
      .left_handle_i  (left_handle),
      .right_key_i    (right_key),
      .right_handle_i (right_handle),
      .lt_o           (lt_w[g]),
      .key_o          (key_w[g]),
      .handle_o       (handle_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_handle_q <= out_handle_d;
      out_key_q    <= out_key_d;
      out_count_q  <= COUNT_W'(count_d);
      status_q     <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_handle_o  = out_handle_q;
  assign out_key_o     = out_key_q;
  assign entry_count_o = out_count_q;
  assign status_o      = status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_INSERT && count_q == CW'(CAPACITY)) |=> $stable(count_q))
    else $error("refused insert changed the entry count");

  a_result_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_valid_o && entry_count_o == COUNT_W'(count_q)))
    else $error("result missing or count mismatch");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full status with room left");

endmodule

FILE: sim/sorted_list_engine_core_tb.sv
// sorted_list_engine_core_tb: self-checking bench for the sorted list engine
// keeps its own ordered list to predict every result; depends on sle_pkg and the core RTL
`timescale 1ns / 1ps

module sorted_list_engine_core_tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQS = 1200;
  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_IN_W-1:0] key;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ACTION_W-1:0]  action_i = ACT_NOP;
  logic [KEY_IN_W-1:0]  sort_key_i = '0;
  logic [HANDLE_W-1:0]  entry_handle_i = '0;
  logic [POS_IN_W-1:0]  position_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [HANDLE_W-1:0]  out_handle_o;
  logic [KEY_IN_W-1:0]  out_key_o;
  logic [COUNT_W-1:0]   entry_count_o;
  logic [STATUS_W-1:0]  status_o;

  // mirror of the list contents
  logic [KEY_IN_W-1:0]  list_keys [LIST_DEPTH];
  logic [HANDLE_W-1:0]  list_handles [LIST_DEPTH];
  int                   list_count = 0;

  list_result_t         pending_results [$];
  int                   fail_count = 0;
  int                   idle_cycles = 0;
  int                   burst_left = 0;

  sorted_list_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .sort_key_i     (sort_key_i),
    .entry_handle_i (entry_handle_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_handle_o   (out_handle_o),
    .out_key_o      (out_key_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic list_result_t predict_list_op(input logic [ACTION_W-1:0] act,
                                                   input logic [KEY_IN_W-1:0] key,
                                                   input logic [HANDLE_W-1:0] hdl,
                                                   input logic [POS_IN_W-1:0] pos);
    list_result_t res;
    int slot;
    res = '0;
    res.status = ST_DONE;
    case (act)
      ACT_INSERT: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes ahead of any equal keys
          slot = 0;
          while (slot < list_count && list_keys[slot] < key) slot++;
          for (int i = list_count; i > slot; i--) begin
            list_keys[i] = list_keys[i-1];
            list_handles[i] = list_handles[i-1];
          end
          list_keys[slot] = key;
          list_handles[slot] = hdl;
          list_count++;
        end
      end
      ACT_REMOVE: begin
        if (int'(pos) >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < list_count; i++) begin
            list_keys[i] = list_keys[i+1];
            list_handles[i] = list_handles[i+1];
          end
          list_count--;
        end
      end
      ACT_READ: begin
        if (int'(pos) >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          res.handle = list_handles[pos];
          res.key = list_keys[pos];
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(list_count);
    return res;
  endfunction

  // one request: optional idle gap at the start of a burst, then hold until taken
  task automatic send_req(input logic [ACTION_W-1:0] act, input logic [KEY_IN_W-1:0] key,
                          input logic [HANDLE_W-1:0] hdl, input logic [POS_IN_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    action_i       <= act;
    sort_key_i     <= key;
    entry_handle_i <= hdl;
    position_i     <= pos;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_results.push_back(predict_list_op(act, key, hdl, pos));
  endtask

  function automatic logic [POS_IN_W-1:0] pick_position();
    if (list_count > 0 && $urandom_range(0, 99) < 85)
      return POS_IN_W'($urandom_range(0, list_count - 1));
    return POS_IN_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return KEY_IN_W'($urandom);
    if (r < 8) return {3'($urandom_range(0, 7)), 13'h0};
    if (r == 8) return '0;
    return '1;
  endfunction

  task automatic test_empty_and_basic();
    send_req(ACT_READ, 16'h0, 16'h0, 4'd0);
    send_req(ACT_REMOVE, 16'h0, 16'h0, 4'd15);
    send_req(ACT_NOP, 16'hffff, 16'hffff, 4'd15);
    send_req(ACT_INSERT, 16'hffff, 16'hffff, 4'd0);
    send_req(ACT_INSERT, 16'h0000, 16'h0000, 4'd15);
    send_req(ACT_INSERT, 16'h8000, 16'h0001, 4'd0);
    send_req(ACT_INSERT, 16'h8000, 16'h0002, 4'd0);
    send_req(ACT_INSERT, 16'hffff, 16'h5aa5, 4'd0);
    for (int p = 0; p < 6; p++) send_req(ACT_READ, 16'h0, 16'h0, POS_IN_W'(p));
    send_req(ACT_REMOVE, 16'h0, 16'h0, 4'd1);
    send_req(ACT_REMOVE, 16'h0, 16'h0, 4'd15);
    send_req(ACT_READ, 16'h0, 16'h0, 4'd1);
    send_req(ACT_NOP, 16'h0, 16'h0, 4'd2);
    send_req(ACT_READ, 16'h0, 16'h0, 4'd3);
  endtask

  task automatic test_full_list();
    while (list_count < LIST_DEPTH) send_req(ACT_INSERT, pick_key(), 16'($urandom), 4'd0);
    send_req(ACT_INSERT, 16'h0000, 16'hffff, 4'd0);
    send_req(ACT_INSERT, 16'hffff, 16'h0000, 4'd0);
    send_req(ACT_READ, 16'h0, 16'h0, 4'd15);
    send_req(ACT_READ, 16'h0, 16'h0, 4'd0);
    send_req(ACT_REMOVE, 16'h0, 16'h0, 4'd15);
    send_req(ACT_READ, 16'h0, 16'h0, 4'd15);
    send_req(ACT_INSERT, 16'hffff, 16'h1234, 4'd0);
    send_req(ACT_REMOVE, 16'h0, 16'h0, 4'd0);
    while (list_count > 0) send_req(ACT_REMOVE, 16'h0, 16'h0, pick_position());
  endtask

  task automatic test_random_mix();
    int ins_pct;
    int r;
    logic [ACTION_W-1:0] act;
    ins_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      // swing between filling and draining so both ends of the list get exercised
      if (n % 60 == 0) ins_pct = $urandom_range(15, 75);
      r = $urandom_range(0, 99);
      if (r < 2) act = ACT_NOP;
      else if (r < ins_pct) act = ACT_INSERT;
      else if (r < ins_pct + (100 - ins_pct) / 2) act = ACT_REMOVE;
      else act = ACT_READ;
      send_req(act, pick_key(), 16'($urandom), pick_position());
    end
  endtask

  // receiver back-pressure, switching pattern every so often
  initial begin
    rx_mode_e mode;
    int span;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int c = 0; c < span; c++) begin
        @(posedge clk_i);
        case (mode)
          RX_OPEN:        out_ready_i <= 1'b1;
          RX_COIN:        out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE:      out_ready_i <= ($urandom_range(0, 3) == 0);
          RX_EVERY_THIRD: out_ready_i <= (c % 3 == 0);
          default:        out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{handle: out_handle_o, key: out_key_o, count: entry_count_o, status: status_o};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result handle=%h key=%h count=%0d status=%0d",
                   $realtime, got.handle, got.key, got.count, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.handle !== want.handle || got.key !== want.key ||
            got.count !== want.count || got.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch exp h=%h k=%h c=%0d s=%0d, got h=%h k=%h c=%0d s=%0d",
                     $realtime, want.handle, want.key, want.count, want.status,
                     got.handle, got.key, got.count, got.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_basic();
    test_full_list();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sorted_list_engine_core.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_cell.sv
hw/rtl/sorted_list_engine_core.sv
sim/sorted_list_engine_core_tb.sv
